FILE: rtl/utf8sd_pkg.sv
// ============================================================================
// utf8sd_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ============================================================================
package utf8sd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CP_W   = 21;
   localparam int unsigned CNT_W  = 3;

   // Default depth of the queue between the classifying front and the
   // result-issuing back.
   localparam int unsigned CMD_QUEUE_DEPTH = 4;

   localparam logic [CP_W-1:0]   MAX_CP_RESET = 21'h10FFFF;

   localparam logic [BYTE_W-1:0] LEAD_LIMIT   = 8'hF7;
   localparam logic [BYTE_W-1:0] ASCII_LIMIT  = 8'h80;
   localparam logic [BYTE_W-1:0] CONT_MASK    = 8'hC0;
   localparam logic [BYTE_W-1:0] CONT_TAG     = 8'h80;
   localparam logic [BYTE_W-1:0] PAYLOAD_MASK = 8'h3F;

   localparam logic [CNT_W-1:0] LEN_TWO   = 3'd2;
   localparam logic [CNT_W-1:0] LEN_THREE = 3'd3;
   localparam logic [CNT_W-1:0] LEN_FOUR  = 3'd4;

   localparam logic [CP_W-1:0] MIN_CP_TWO   = 21'h000080;
   localparam logic [CP_W-1:0] MIN_CP_THREE = 21'h000800;
   localparam logic [CP_W-1:0] MIN_CP_FOUR  = 21'h010000;

   // One queued command: cnt results, of which all but the final one are
   // errors with a zero code point; the final one carries cp and err.
   typedef struct packed {
      logic [CNT_W-1:0] cnt;
      logic [CP_W-1:0]  cp;
      logic             err;
   } cmd_type;

endpackage

FILE: rtl/utf8sd_front.sv
// ============================================================================
// utf8sd_front
// Accepts bytes, tracks the open sequence and classifies each byte into a
// command describing the results it causes.
// ============================================================================
module utf8sd_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   input  logic [utf8sd_pkg::BYTE_W-1:0]      req_in_byte,
   input  logic                               q_full,
   input  logic                               csr_valid,
   input  logic [utf8sd_pkg::CP_W-1:0]        csr_max_code_point,
   output logic                               cmd_push,
   output utf8sd_pkg::cmd_type                cmd
);
   import utf8sd_pkg::*;

   logic [1:0]       rem_ff, rem_in;
   logic [1:0]       taken_ff, taken_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CP_W-1:0]  part_ff, part_in;
   logic [CP_W-1:0]  max_ff, max_in;

   logic             accept;
   logic [BYTE_W-1:0] b;

   logic             lead_has;
   logic [CP_W-1:0]  lead_cp;
   logic             lead_err;
   logic             lead_open;
   logic [CNT_W-1:0] lead_len;
   logic [CP_W-1:0]  lead_part;

   logic             is_cont;
   logic [CP_W-1:0]  shifted;
   logic [CP_W-1:0]  min_cp;
   logic             rejected;

   assign accept  = req_push && !q_full;
   assign b       = req_in_byte;
   assign is_cont = (b & CONT_MASK) == CONT_TAG;
   assign shifted = {part_ff[CP_W-7:0], b[5:0] & PAYLOAD_MASK[5:0]};

   // Classification of a byte seen with no sequence open.
   always_comb begin
      lead_has  = 1'b0;
      lead_cp   = '0;
      lead_err  = 1'b0;
      lead_open = 1'b0;
      lead_len  = '0;
      lead_part = '0;
      if (b > LEAD_LIMIT) begin
         lead_has = 1'b1;
         lead_err = 1'b1;
      end else if (b < ASCII_LIMIT) begin
         lead_has = 1'b1;
         lead_cp  = {{(CP_W-BYTE_W){1'b0}}, b};
      end else if (is_cont) begin
         lead_has = 1'b1;
         lead_err = 1'b1;
      end else if (b[7:5] == 3'b110) begin
         lead_open = 1'b1;
         lead_len  = LEN_TWO;
         lead_part = {{(CP_W-5){1'b0}}, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         lead_open = 1'b1;
         lead_len  = LEN_THREE;
         lead_part = {{(CP_W-4){1'b0}}, b[3:0]};
      end else begin
         lead_open = 1'b1;
         lead_len  = LEN_FOUR;
         lead_part = {{(CP_W-3){1'b0}}, b[2:0]};
      end
   end

   always_comb begin
      case (len_ff)
         LEN_TWO:   min_cp = MIN_CP_TWO;
         LEN_THREE: min_cp = MIN_CP_THREE;
         default:   min_cp = MIN_CP_FOUR;
      endcase
   end

   assign rejected = (shifted < min_cp) || (shifted > max_ff);

   always_comb begin
      rem_in   = rem_ff;
      taken_in = taken_ff;
      len_in   = len_ff;
      part_in  = part_ff;
      cmd      = '0;
      if (accept) begin
         if (rem_ff == 2'd0 || !is_cont) begin
            // Drop any open sequence, one error per byte taken, then treat
            // the byte as a fresh lead.
            cmd.cnt = (rem_ff == 2'd0) ? {2'b00, lead_has}
                                       : {1'b0, taken_ff} + {2'b00, lead_has};
            cmd.cp  = lead_has ? lead_cp : '0;
            cmd.err = lead_has ? lead_err : 1'b1;
            if (lead_open) begin
               rem_in   = lead_len[1:0] - 2'd1;
               taken_in = 2'd1;
               len_in   = lead_len;
               part_in  = lead_part;
            end else begin
               rem_in   = '0;
               taken_in = '0;
               len_in   = '0;
               part_in  = '0;
            end
         end else if (rem_ff == 2'd1) begin
            // Sequence complete.
            rem_in   = '0;
            taken_in = '0;
            len_in   = '0;
            part_in  = '0;
            if (rejected) begin
               cmd.cnt = len_ff;
               cmd.cp  = '0;
               cmd.err = 1'b1;
            end else begin
               cmd.cnt = 3'd1;
               cmd.cp  = shifted;
               cmd.err = 1'b0;
            end
         end else begin
            rem_in   = rem_ff - 2'd1;
            taken_in = taken_ff + 2'd1;
            part_in  = shifted;
         end
      end
   end

   assign cmd_push = accept && (cmd.cnt != '0);
   assign max_in   = csr_valid ? csr_max_code_point : max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= '0;
         taken_ff <= '0;
         len_ff   <= '0;
         part_ff  <= '0;
         max_ff   <= MAX_CP_RESET;
      end else begin
         rem_ff   <= rem_in;
         taken_ff <= taken_in;
         len_ff   <= len_in;
         part_ff  <= part_in;
         max_ff   <= max_in;
      end
   end

endmodule

FILE: rtl/utf8sd_queue.sv
// ============================================================================
// utf8sd_queue
// Small first-in first-out queue of commands between front and back.
// ============================================================================
module utf8sd_queue #(
   parameter int unsigned DEPTH = utf8sd_pkg::CMD_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  utf8sd_pkg::cmd_type wr_data,
   input  logic                rd_en,
   output utf8sd_pkg::cmd_type rd_data,
   output logic                full,
   output logic                empty
);
   import utf8sd_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_QW = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]  count_ff, count_in;
   logic               do_wr, do_rd;

   assign full    = count_ff == FULL_CNT;
   assign empty   = count_ff == '0;
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/utf8sd_back.sv
// ============================================================================
// utf8sd_back
// Expands queued commands into result transactions, one per cycle while rsp_pop takes them.
// ============================================================================
module utf8sd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  utf8sd_pkg::cmd_type          q_data,
   input  logic                         q_empty,
   output logic                         q_pop,
   input  logic                         rsp_pop,
   output logic                         rsp_empty,
   output logic [utf8sd_pkg::CP_W-1:0]  rsp_code_point,
   output logic                         rsp_is_error,
   output logic                         rsp_last_of_run
);
   import utf8sd_pkg::*;

   logic             valid_ff, valid_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CP_W-1:0]  cp_ff, cp_in;
   logic             err_ff, err_in;
   logic             last;
   logic             load;

   assign last = cnt_ff == 3'd1;
   // The holding register takes the next command once it is empty or its
   // final result is being taken.
   assign load  = !valid_ff || (rsp_pop && last);
   assign q_pop = load && !q_empty;

   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      cp_in    = cp_ff;
      err_in   = err_ff;
      if (load) begin
         valid_in = !q_empty;
         cnt_in   = q_data.cnt;
         cp_in    = q_data.cp;
         err_in   = q_data.err;
      end else if (rsp_pop) begin
         cnt_in = cnt_ff - 3'd1;
      end
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_last_of_run = last;
   assign rsp_code_point  = last ? cp_ff : '0;
   assign rsp_is_error    = last ? err_ff : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_ff  <= cp_in;
      err_ff <= err_in;
   end

endmodule

FILE: rtl/utf8_stream_decoder.sv
// ============================================================================
// utf8_stream_decoder
// Streaming UTF-8 decoder: one byte in, zero to four code point results out.
// ============================================================================
// Usage:
// Bytes enter through a queue-like port: a transaction happens at a rising
// clock edge with req_push high and req_full low. Results leave through a
// queue-like port: the oldest result sits on rsp_code_point, rsp_is_error
// and rsp_last_of_run while rsp_empty is low, and is taken by a transaction
// at an edge with rsp_pop high. rsp_last_of_run marks the final result that
// one byte causes; a lead byte with no sequence open, or a continuation inside
// an unfinished sequence, causes no result at all.
// The largest accepted code point is written through the csr_ channel, which
// is always ready; it should only be written while the decoder is idle.
// A result passes through the command queue and the back end's holding
// register before it reaches the output. Bytes are taken one per cycle while
// req_full is low; the back end issues one result per cycle while rsp_pop is high.
// A command queue (QUEUE_DEPTH entries) sits between the classifying front
// end and the issuing back end, so a stalled receiver only blocks input once
// that queue and the output register are full, shown by req_full.
// Synchronous reset empties the queue and output, drops any open sequence
// and restores the limit to U+10FFFF.
// ============================================================================
module utf8_stream_decoder #(
   parameter int unsigned QUEUE_DEPTH = utf8sd_pkg::CMD_QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [utf8sd_pkg::BYTE_W-1:0]     req_in_byte,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [utf8sd_pkg::CP_W-1:0]       rsp_code_point,
   output logic                              rsp_is_error,
   output logic                              rsp_last_of_run,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [utf8sd_pkg::CP_W-1:0]       csr_max_code_point
);
   import utf8sd_pkg::*;

   cmd_type cmd;
   cmd_type q_data;
   logic    cmd_push;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;

   // The register write never stalls.
   assign csr_ready = 1'b1;
   assign req_full  = q_full;

   // Front end: tracks the open sequence and turns each byte into a command.
   utf8sd_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_in_byte        (req_in_byte),
      .q_full             (q_full),
      .csr_valid          (csr_valid),
      .csr_max_code_point (csr_max_code_point),
      .cmd_push           (cmd_push),
      .cmd                (cmd)
   );

   // Decoupling queue; bytes that cause no result never enter it.
   utf8sd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_data (cmd),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .full    (q_full),
      .empty   (q_empty)
   );

   // Back end: issues the results of each command, one per cycle while rsp_pop takes them.
   utf8sd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_data          (q_data),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_code_point  (rsp_code_point),
      .rsp_is_error    (rsp_is_error),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

FILE: rtl/utf8sd_checker.sv
// ============================================================================
// utf8sd_checker
// Port-level checks of the UTF-8 stream decoder, bound to the top level.
// ============================================================================
module utf8sd_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_full,
   input  logic                              rsp_empty,
   input  logic                              rsp_pop,
   input  logic [utf8sd_pkg::CP_W-1:0]       rsp_code_point,
   input  logic                              rsp_is_error,
   input  logic                              rsp_last_of_run
);

   // After reset there is nothing to deliver and room to accept.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("decoder not empty after reset");

   // Only the final result of a byte can be a code point.
   a_inner_is_error: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_last_of_run) |-> (rsp_is_error && rsp_code_point == '0))
      else $error("non-final result is not an error");

   // An error never carries a code point.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_is_error) |-> (rsp_code_point == '0))
      else $error("error result with non-zero code point");

   // A waiting result is held until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_code_point) && $stable(rsp_is_error)
          && $stable(rsp_last_of_run)))
      else $error("waiting result changed before it was taken");

endmodule

bind utf8_stream_decoder utf8sd_checker u_checker (.*);
